[rtl/core/kscb_pkg.sv]
// Package for the keypad scan code buffer: payload structs, register
// indexes, status codes and the key lookup function.
// No dependencies.
`timescale 1ns / 1ps

package kscb_pkg;

    localparam int unsigned TICK_W    = 24;
    localparam int unsigned KEY_W     = 7;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [TICK_W-1:0] ELAPSED_MAX = '1;

    localparam logic [TICK_W-1:0] DEBOUNCE_RESET = 24'd200000;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET  = 24'd2000000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE  = 2'd2;

    // Request types.
    localparam logic [1:0] REQ_TICK     = 2'd0;
    localparam logic [1:0] REQ_ROW_EDGE = 2'd1;
    localparam logic [1:0] REQ_COLUMNS  = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_TICK         = 3'd0;
    localparam logic [2:0] ST_DEBOUNCED    = 3'd1;
    localparam logic [2:0] ST_SCAN_STARTED = 3'd2;
    localparam logic [2:0] ST_RESCAN       = 3'd3;
    localparam logic [2:0] ST_KEY          = 3'd4;
    localparam logic [2:0] ST_IGNORED      = 3'd5;

    localparam logic [KEY_W-1:0] KEY_NONE = '0;

    typedef struct packed {
        logic [1:0] req_type;
        logic [1:0] row_index;
        logic [2:0] column_levels;
    } in_item_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [KEY_W-1:0] key_code;
        logic             captured;
        logic             code_complete;
        logic [KEY_W-1:0] code_first;
        logic [KEY_W-1:0] code_second;
        logic [KEY_W-1:0] code_third;
    } out_item_t;

    typedef struct packed {
        logic [TICK_W-1:0] debounce_ticks;
        logic [TICK_W-1:0] code_timeout_ticks;
        logic              capture_mode;
    } cfg_t;

    // ASCII of the key at a row and column of the telephone keypad.
    function automatic logic [KEY_W-1:0] key_ascii(input logic [1:0] row,
                                                   input logic [1:0] col);
        logic [KEY_W-1:0] code;
        code = KEY_NONE;
        case (row)
            2'd0: begin
                case (col)
                    2'd0:    code = 7'h31;
                    2'd1:    code = 7'h32;
                    default: code = 7'h33;
                endcase
            end
            2'd1: begin
                case (col)
                    2'd0:    code = 7'h34;
                    2'd1:    code = 7'h35;
                    default: code = 7'h36;
                endcase
            end
            2'd2: begin
                case (col)
                    2'd0:    code = 7'h37;
                    2'd1:    code = 7'h38;
                    default: code = 7'h39;
                endcase
            end
            default: begin
                case (col)
                    2'd0:    code = 7'h2A;
                    2'd1:    code = 7'h30;
                    default: code = 7'h23;
                endcase
            end
        endcase
        return code;
    endfunction

endpackage

[rtl/core/kscb_cfg_regs.sv]
// Configuration registers of the keypad scan code buffer.
// Depends on kscb_pkg.
`timescale 1ns / 1ps

module kscb_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [kscb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [kscb_pkg::TICK_W-1:0]   cfg_data,
    output kscb_pkg::cfg_t                cfg
);

    kscb_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks     <= kscb_pkg::DEBOUNCE_RESET;
            cfg_reg.code_timeout_ticks <= kscb_pkg::TIMEOUT_RESET;
            cfg_reg.capture_mode       <= 1'b0;
        end else if (cfg_valid) begin
            // Writes to an unknown index are dropped.
            case (cfg_index)
                kscb_pkg::CFG_DEBOUNCE: cfg_reg.debounce_ticks     <= cfg_data;
                kscb_pkg::CFG_TIMEOUT:  cfg_reg.code_timeout_ticks <= cfg_data;
                kscb_pkg::CFG_CAPTURE:  cfg_reg.capture_mode       <= cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

[rtl/core/kscb_engine.sv]
// Scan state, elapsed-time counter and three-key code buffer. Computes the
// result of one item and updates the state when the item advances.
// Depends on kscb_pkg.
`timescale 1ns / 1ps

module kscb_engine (
    input  logic                aclk,
    input  logic                aresetn,
    input  kscb_pkg::cfg_t      cfg,
    input  kscb_pkg::in_item_t  item,
    input  logic                advance,
    output kscb_pkg::out_item_t result
);

    logic                               scanning_reg, scanning_next;
    logic [1:0]                         latched_row_reg, latched_row_next;
    logic [kscb_pkg::TICK_W-1:0]        elapsed_reg, elapsed_next;
    logic [2:0][kscb_pkg::KEY_W-1:0]    slots_reg, slots_next;
    logic [1:0]                         position_reg, position_next;

    always_comb begin
        logic [2:0]                  status;
        logic [kscb_pkg::KEY_W-1:0]  key;
        logic                        cap;
        logic                        one_col;
        logic [1:0]                  col;
        logic [1:0]                  pos;

        status           = kscb_pkg::ST_IGNORED;
        key              = kscb_pkg::KEY_NONE;
        cap              = 1'b0;
        one_col          = 1'b1;
        col              = 2'd0;
        pos              = position_reg;
        scanning_next    = scanning_reg;
        latched_row_next = latched_row_reg;
        elapsed_next     = elapsed_reg;
        slots_next       = slots_reg;
        position_next    = position_reg;

        case (item.column_levels)
            3'b001:  col = 2'd0;
            3'b010:  col = 2'd1;
            3'b100:  col = 2'd2;
            default: one_col = 1'b0;
        endcase

        case (item.req_type)
            kscb_pkg::REQ_TICK: begin
                if (elapsed_reg != kscb_pkg::ELAPSED_MAX) begin
                    elapsed_next = elapsed_reg + 1'b1;
                end
                status = kscb_pkg::ST_TICK;
            end
            kscb_pkg::REQ_ROW_EDGE: begin
                if (scanning_reg) begin
                    status = kscb_pkg::ST_IGNORED;
                end else if (elapsed_reg < cfg.debounce_ticks) begin
                    status = kscb_pkg::ST_DEBOUNCED;
                end else begin
                    scanning_next    = 1'b1;
                    latched_row_next = item.row_index;
                    status           = kscb_pkg::ST_SCAN_STARTED;
                end
            end
            kscb_pkg::REQ_COLUMNS: begin
                if (!scanning_reg) begin
                    status = kscb_pkg::ST_IGNORED;
                end else if (one_col) begin
                    key = kscb_pkg::key_ascii(latched_row_reg, col);
                    if (cfg.capture_mode) begin
                        cap = 1'b1;
                    end else begin
                        // A long pause restarts the code and clears slot 2;
                        // slots 0 and 1 stay until they are overwritten.
                        if (elapsed_reg > cfg.code_timeout_ticks) begin
                            pos           = 2'd0;
                            slots_next[2] = kscb_pkg::KEY_NONE;
                        end
                        if (pos >= 2'd2) begin
                            pos = 2'd2;
                            if (slots_next[2] != kscb_pkg::KEY_NONE) begin
                                slots_next[0] = slots_next[1];
                                slots_next[1] = slots_next[2];
                                slots_next[2] = kscb_pkg::KEY_NONE;
                            end
                        end
                        slots_next[pos] = key;
                        position_next   = (pos < 2'd2) ? pos + 2'd1 : pos;
                    end
                    scanning_next = 1'b0;
                    elapsed_next  = '0;
                    status        = kscb_pkg::ST_KEY;
                end else begin
                    status = kscb_pkg::ST_RESCAN;
                end
            end
            default: status = kscb_pkg::ST_IGNORED;
        endcase

        result.status        = status;
        result.key_code      = key;
        result.captured      = cap;
        result.code_complete = (position_next >= 2'd2) &&
                               (slots_next[2] != kscb_pkg::KEY_NONE);
        result.code_first    = slots_next[0];
        result.code_second   = slots_next[1];
        result.code_third    = slots_next[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scanning_reg    <= 1'b0;
            latched_row_reg <= 2'd0;
            elapsed_reg     <= '0;
            slots_reg       <= '0;
            position_reg    <= 2'd0;
        end else if (advance) begin
            scanning_reg    <= scanning_next;
            latched_row_reg <= latched_row_next;
            elapsed_reg     <= elapsed_next;
            slots_reg       <= slots_next;
            position_reg    <= position_next;
        end
    end

endmodule

[rtl/core/keypad_scan_code_buffer_unit.sv]
// Top level of the keypad scan code buffer: input register, result register
// and the handshakes around them.
// Depends on kscb_pkg, kscb_cfg_regs and kscb_engine.
`timescale 1ns / 1ps

// Usage:
// Items (microsecond tick, row falling edge or column sample) enter on the
// s_ channel; each one yields exactly one result on the m_ channel, in order.
// Registers are written on the cfg_ channel, which is always ready; write
// them only while no item is in flight.
// An item transferred on s_ is held in the input register and goes through
// the scan and code-buffer logic into the result register once that
// register is empty or its result is being taken; it shows on m_ from
// then on. Throughput is one item per cycle while m_ready stays high,
// set by the single pass from input register to result register; the
// state is updated as the item advances.
// When the receiver stalls, the result register holds its item and the
// input register holds one more; s_ready then drops until m_ready returns.
// Reset empties both registers, clears the scan state, the elapsed counter
// and the code buffer, and returns the registers to their defaults.
module keypad_scan_code_buffer_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  kscb_pkg::in_item_t             s_item,
    output logic                           m_valid,
    input  logic                           m_ready,
    output kscb_pkg::out_item_t            m_result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [kscb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [kscb_pkg::TICK_W-1:0]    cfg_data
);

    kscb_pkg::cfg_t      cfg;
    kscb_pkg::in_item_t  item_reg;
    logic                item_valid_reg;
    kscb_pkg::out_item_t result;
    kscb_pkg::out_item_t result_reg;
    logic                result_valid_reg;
    logic                advance;

    assign advance  = item_valid_reg && (!result_valid_reg || m_ready);
    assign s_ready  = !item_valid_reg || advance;
    assign m_valid  = result_valid_reg;
    assign m_result = result_reg;

    kscb_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kscb_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .item    (item_reg),
        .advance (advance),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_ready) begin
            item_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            result_valid_reg <= 1'b0;
        end else if (advance) begin
            result_valid_reg <= 1'b1;
        end else if (m_ready) begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

endmodule

[bench/keypad_scan_code_buffer_unit_tb.sv]
// Self-checking testbench for keypad_scan_code_buffer_unit: directed and random keypad
// traffic, a scoreboard that predicts every result, and random idling on both channels.
// Depends on kscb_pkg and the keypad_scan_code_buffer_unit RTL.
`timescale 1ns / 1ps

module keypad_scan_code_buffer_unit_tb;
    import kscb_pkg::*;

    localparam logic [1:0] REQ_UNDEFINED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [TICK_W-1:0] TICKS_MAX = '1;
    localparam string KEY_CHARS = "123456789*0#";
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned ITEMS_PER_PHASE = 155;

    class keypad_tracker;
        logic [TICK_W-1:0] debounce;
        logic [TICK_W-1:0] timeout;
        logic              capture;
        logic              scanning;
        logic [1:0]        row_held;
        logic [TICK_W-1:0] elapsed;
        logic [KEY_W-1:0]  slots [3];
        logic [1:0]        position;
        out_item_t         pending_results [$];
        int                mismatches;

        function new();
            debounce   = DEBOUNCE_RESET;
            timeout    = TIMEOUT_RESET;
            capture    = 1'b0;
            scanning   = 1'b0;
            row_held   = '0;
            elapsed    = '0;
            slots      = '{default: '0};
            position   = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] data);
            case (idx)
                CFG_DEBOUNCE: debounce = data;
                CFG_TIMEOUT:  timeout  = data;
                CFG_CAPTURE:  capture  = data[0];
                default: ;
            endcase
        endfunction

        function void add_to_code(logic [KEY_W-1:0] key);
            if (elapsed > timeout) begin
                position = 0;
                slots[2] = '0;
            end
            if (position >= 2) begin
                position = 2;
                if (slots[2] != '0) begin
                    slots[0] = slots[1];
                    slots[1] = slots[2];
                    slots[2] = '0;
                end
            end
            slots[position] = key;
            if (position < 2)
                position++;
        endfunction

        // Advances the keypad state by one transferred item and queues its result.
        function void note_item(in_item_t it);
            out_item_t r;
            int        count;
            int        col;
            r = '0;
            r.status = ST_IGNORED;
            r.key_code = KEY_NONE;
            case (it.req_type)
                REQ_TICK: begin
                    if (elapsed != ELAPSED_MAX)
                        elapsed++;
                    r.status = ST_TICK;
                end
                REQ_ROW_EDGE: begin
                    if (scanning) begin
                        r.status = ST_IGNORED;
                    end else if (elapsed < debounce) begin
                        r.status = ST_DEBOUNCED;
                    end else begin
                        scanning = 1'b1;
                        row_held = it.row_index;
                        r.status = ST_SCAN_STARTED;
                    end
                end
                REQ_COLUMNS: begin
                    if (scanning) begin
                        count = 0;
                        col = 0;
                        for (int i = 0; i < 3; i++) begin
                            if (it.column_levels[i]) begin
                                count++;
                                col = i;
                            end
                        end
                        if (count == 1) begin
                            r.key_code = KEY_W'(KEY_CHARS[int'(row_held) * 3 + col]);
                            if (capture)
                                r.captured = 1'b1;
                            else
                                add_to_code(r.key_code);
                            scanning = 1'b0;
                            elapsed = '0;
                            r.status = ST_KEY;
                        end else begin
                            r.status = ST_RESCAN;
                        end
                    end
                end
                default: r.status = ST_IGNORED;
            endcase
            r.code_complete = (position >= 2) && (slots[2] != '0);
            r.code_first  = slots[0];
            r.code_second = slots[1];
            r.code_third  = slots[2];
            pending_results.push_back(r);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with no item pending: status=%0d key=%h",
                             got.status, got.key_code);
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status || got.key_code !== want.key_code ||
                got.captured !== want.captured || got.code_complete !== want.code_complete ||
                got.code_first !== want.code_first || got.code_second !== want.code_second ||
                got.code_third !== want.code_third) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: expected st=%0d key=%h cap=%b full=%b code=%h %h %h",
                             want.status, want.key_code, want.captured, want.code_complete,
                             want.code_first, want.code_second, want.code_third);
                    $display("       actual   st=%0d key=%h cap=%b full=%b code=%h %h %h",
                             got.status, got.key_code, got.captured, got.code_complete,
                             got.code_first, got.code_second, got.code_third);
                end
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_item_t             s_item = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_item_t            m_result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TICK_W-1:0]    cfg_data = '0;

    keypad_tracker tracker;
    int            burst_left = 0;
    int            items_sent = 0;
    int unsigned   cycles = 0;
    logic [10:0]   ready_pattern = 11'b11011100101;

    keypad_scan_code_buffer_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: checks every transfer and stalls in one of three modes that
    // take turns: always ready, a fixed rotating pattern, random.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_result(m_result);
        ready_pattern <= {ready_pattern[0], ready_pattern[10:1]};
        case ((cycles / 256) % 3)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ready_pattern[0];
            default: m_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    function automatic in_item_t make_item(logic [1:0] req, logic [1:0] row, logic [2:0] cols);
        in_item_t it;
        it.req_type = req;
        it.row_index = row;
        it.column_levels = cols;
        return it;
    endfunction

    // Valid is only lowered when a real gap follows, so it never drops and
    // rises within one time step.
    task automatic send_item(input in_item_t it, input bit steady);
        int gap;
        if (burst_left == 0) begin
            gap = steady ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_valid <= 1'b1;
        s_item <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.note_item(it);
        burst_left--;
        if (it.req_type != REQ_UNDEFINED)
            items_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        while (tracker.pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        tracker.write_reg(idx, data);
    endtask

    task automatic program_regs(input logic [TICK_W-1:0] deb, input logic [TICK_W-1:0] tmo,
                                input logic cap);
        drain();
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_TIMEOUT, tmo);
        write_reg(CFG_CAPTURE, {{(TICK_W-1){1'b0}}, cap});
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_UNUSED, TICK_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // A key press as the scanner sees it: idle ticks, a row edge, a few
    // ambiguous column samples, then a sample with a single high column.
    task automatic key_press(input bit steady);
        int lim;
        int n;
        logic [2:0] bad_cols [5];
        bad_cols = '{3'b000, 3'b011, 3'b101, 3'b110, 3'b111};
        lim = (tracker.debounce > tracker.timeout) ? int'(tracker.debounce)
                                                   : int'(tracker.timeout);
        lim = (lim > 21) ? 24 : lim + 3;
        n = $urandom_range(0, lim);
        repeat (n) send_item(make_item(REQ_TICK, 2'($urandom), 3'($urandom)), steady);
        send_item(make_item(REQ_ROW_EDGE, 2'($urandom), 3'($urandom)), steady);
        n = $urandom_range(0, 2);
        repeat (n) begin
            if ($urandom_range(0, 3) == 0)
                send_item(make_item(REQ_TICK, 2'($urandom), 3'($urandom)), steady);
            send_item(make_item(REQ_COLUMNS, 2'($urandom), bad_cols[$urandom_range(0, 4)]),
                      steady);
        end
        if ($urandom_range(0, 4) == 0)
            send_item(make_item(REQ_ROW_EDGE, 2'($urandom), 3'($urandom)), steady);
        send_item(make_item(REQ_COLUMNS, 2'($urandom), 3'(1 << $urandom_range(0, 2))), steady);
    endtask

    task automatic run_random(input int budget, input bit steady);
        int quota;
        quota = items_sent + budget;
        while (items_sent < quota) begin
            if ($urandom_range(0, 9) < 8)
                key_press(steady);
            else
                send_item(make_item(2'($urandom), 2'($urandom), 3'($urandom)), steady);
        end
    endtask

    initial begin
        tracker = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Default registers: the first row edge comes too soon after reset.
        send_item(make_item(REQ_ROW_EDGE, 2'd0, 3'b000), 1'b0);
        send_item(make_item(REQ_COLUMNS, 2'd3, 3'b001), 1'b0);
        send_item(make_item(REQ_UNDEFINED, 2'd3, 3'b111), 1'b0);
        send_item(make_item(REQ_TICK, 2'd0, 3'b000), 1'b0);

        program_regs('0, TICKS_MAX, 1'b0);
        send_item(make_item(REQ_ROW_EDGE, 2'd0, 3'b000), 1'b1);
        send_item(make_item(REQ_ROW_EDGE, 2'd2, 3'b000), 1'b1);
        send_item(make_item(REQ_COLUMNS, 2'd0, 3'b000), 1'b1);
        send_item(make_item(REQ_COLUMNS, 2'd0, 3'b111), 1'b1);
        send_item(make_item(REQ_COLUMNS, 2'd0, 3'b101), 1'b1);
        send_item(make_item(REQ_COLUMNS, 2'd0, 3'b001), 1'b1);
        send_item(make_item(REQ_ROW_EDGE, 2'd1, 3'b000), 1'b1);
        send_item(make_item(REQ_COLUMNS, 2'd1, 3'b010), 1'b1);
        send_item(make_item(REQ_ROW_EDGE, 2'd2, 3'b000), 1'b1);
        send_item(make_item(REQ_COLUMNS, 2'd2, 3'b100), 1'b1);
        // The buffer is full from here on, so each key shifts it.
        send_item(make_item(REQ_ROW_EDGE, 2'd3, 3'b000), 1'b1);
        send_item(make_item(REQ_COLUMNS, 2'd3, 3'b001), 1'b1);
        send_item(make_item(REQ_ROW_EDGE, 2'd3, 3'b000), 1'b1);
        send_item(make_item(REQ_COLUMNS, 2'd3, 3'b010), 1'b1);
        send_item(make_item(REQ_ROW_EDGE, 2'd3, 3'b000), 1'b1);
        send_item(make_item(REQ_COLUMNS, 2'd3, 3'b100), 1'b1);

        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                0: program_regs(24'd2, 24'd6, 1'b0);
                1: program_regs('0, '0, 1'b0);
                2: program_regs(24'd5, 24'd12, 1'b1);
                3: program_regs(TICKS_MAX, '0, 1'b0);
                4: program_regs('0, TICKS_MAX, 1'b1);
                default: program_regs(TICK_W'($urandom_range(0, 6)),
                                      TICK_W'($urandom_range(0, 15)),
                                      1'($urandom_range(0, 1)));
            endcase
            // With the longest debounce every row edge is refused, so keep it short.
            run_random((phase == 3) ? 40 : ITEMS_PER_PHASE, (phase % 3) == 1);
        end

        drain();
        repeat (8) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/kscb_pkg.sv
rtl/core/kscb_cfg_regs.sv
rtl/core/kscb_engine.sv
rtl/core/keypad_scan_code_buffer_unit.sv
bench/keypad_scan_code_buffer_unit_tb.sv
